// ===== rtl/priority_queue_with_aging_unit_macros.svh =====
// assertion macros for the priority queue with aging unit
`ifndef PRIORITY_QUEUE_WITH_AGING_UNIT_MACROS_SVH
`define PRIORITY_QUEUE_WITH_AGING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PQA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PQA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PQA_ASSERT_IMP(label, ante, cons, msg)
`define PQA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/pqa_pkg.sv =====
// shared constants and types of the priority queue with aging unit
package pqa_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int PRIORITY_BITS = 4;
    localparam int TAG_BITS      = 16;

    localparam int IDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_BITS = TAG_BITS + PRIORITY_BITS;
    localparam int MS_BITS    = 16;
    localparam int STATUS_BITS = 3;
    localparam int MODE_BITS  = 2;

    localparam logic [MS_BITS-1:0] THRESHOLD_RESET = MS_BITS'(5000);
    localparam logic [MS_BITS-1:0] MS_MAX          = '1;
    localparam logic [PRIORITY_BITS-1:0] FREE_PRIORITY = '0;

    localparam logic [MODE_BITS-1:0] MODE_INSERT  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_TICK    = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_FINISH  = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_ACK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_DISPATCH   = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY_DONE = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY_WAIT = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL       = 3'd4;

    typedef struct packed {
        logic [TAG_BITS-1:0]      tag;
        logic [PRIORITY_BITS-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic [IDX_BITS-1:0] idx;
        t_entry              entry;
        logic                aged;
    } t_pick;

endpackage

// ===== rtl/pqa_ram.sv =====
// generic single-write, single-read ram with registered read data
module pqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pqa_pick.sv =====
// selection unit: tracks best and oldest free-class entry over a scan
module pqa_pick (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_valid,
    input  logic [pqa_pkg::IDX_BITS-1:0]  i_idx,
    input  pqa_pkg::t_entry               i_entry,
    input  logic                          i_age_en,
    output pqa_pkg::t_pick                o_pick
);
    import pqa_pkg::*;

    t_entry              r_best;
    logic [IDX_BITS-1:0] r_best_idx;
    t_entry              r_zero;
    logic [IDX_BITS-1:0] r_zero_idx;
    logic                r_zero_found;

    logic w_take_best;
    logic w_take_zero;

    // strictly greater keeps the oldest among equals
    assign w_take_best = i_valid && ((i_idx == '0) || (i_entry.prio > r_best.prio));
    assign w_take_zero = i_valid && !r_zero_found && (i_entry.prio == FREE_PRIORITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_found <= 1'b0;
        end else if (i_start) begin
            r_zero_found <= 1'b0;
        end else if (w_take_zero) begin
            r_zero_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_best) begin
            r_best     <= i_entry;
            r_best_idx <= i_idx;
        end
        if (w_take_zero) begin
            r_zero     <= i_entry;
            r_zero_idx <= i_idx;
        end
    end

    always_comb begin
        if (i_age_en && r_zero_found) begin
            o_pick.idx   = r_zero_idx;
            o_pick.entry = r_zero;
            o_pick.aged  = 1'b1;
        end else begin
            o_pick.idx   = r_best_idx;
            o_pick.entry = r_best;
            o_pick.aged  = 1'b0;
        end
    end

endmodule

// ===== rtl/priority_queue_with_aging_unit.sv =====
// top level of the priority queue with aging unit
// Job scheduler holding up to 16 jobs in arrival order in a single-port-read ram. Insert,
// tick, finish and a dequeue on an empty store each pass through the exec and response
// states before the result is registered. A dequeue on n jobs reads the store once per
// cycle through a shared compare unit, then closes the gap left by the dispatched job
// at position p one entry per cycle. A new request is taken once the previous result
// sits in the output register, even if it has not yet been collected.
`include "priority_queue_with_aging_unit_macros.svh"
module priority_queue_with_aging_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pqa_pkg::MS_BITS-1:0]          i_cfg_wdata,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [pqa_pkg::MODE_BITS-1:0]        i_mode,
    input  logic [pqa_pkg::TAG_BITS-1:0]         i_job_tag,
    input  logic [pqa_pkg::PRIORITY_BITS-1:0]    i_job_priority,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pqa_pkg::STATUS_BITS-1:0]      o_status,
    output logic [pqa_pkg::TAG_BITS-1:0]         o_out_job_tag,
    output logic [pqa_pkg::PRIORITY_BITS-1:0]    o_out_priority,
    output logic                                 o_by_aging,
    output logic                                 o_closed,
    output logic [pqa_pkg::CNT_BITS-1:0]         o_occupancy
);
    import pqa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]               r_state, n_state;
    logic [MODE_BITS-1:0]     r_mode;
    logic [TAG_BITS-1:0]      r_tag;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [CNT_BITS-1:0]      r_count, n_count;
    logic [MS_BITS-1:0]       r_since, n_since;
    logic                     r_fin, n_fin;
    logic [MS_BITS-1:0]       r_thr;
    logic [IDX_BITS-1:0]      r_idx, n_idx;
    t_pick                    r_sel;

    logic                     r_out_valid;
    logic [STATUS_BITS-1:0]   r_status, n_status;
    logic [TAG_BITS-1:0]      r_otag, n_otag;
    logic [PRIORITY_BITS-1:0] r_oprio, n_oprio;
    logic                     r_aged, n_aged;
    logic                     r_closed;
    logic [CNT_BITS-1:0]      r_occ;

    logic                     w_accept;
    logic                     w_resp_fire;
    logic                     w_full;
    logic                     w_ram_we;
    logic [IDX_BITS-1:0]      w_ram_waddr;
    logic [ENTRY_BITS-1:0]    w_ram_wdata;
    logic [IDX_BITS-1:0]      w_ram_raddr;
    logic [ENTRY_BITS-1:0]    w_ram_rdata;
    t_entry                   w_rd_entry;
    t_entry                   w_new_entry;
    logic                     w_pick_start;
    logic                     w_pick_valid;
    t_pick                    w_pick;
    logic [CNT_BITS-1:0]      w_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_resp_fire = (r_state == S_RESP) && (!r_out_valid || i_out_ready);
    assign w_full      = (r_count >= CNT_BITS'(QUEUE_DEPTH));
    assign w_rd_entry  = t_entry'(w_ram_rdata);
    assign w_last      = CNT_BITS'(r_count - 1'b1);
    assign w_new_entry = '{tag: r_tag, prio: r_prio};

    pqa_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    pqa_pick u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_pick_start),
        .i_valid  (w_pick_valid),
        .i_idx    (r_idx),
        .i_entry  (w_rd_entry),
        .i_age_en (r_since >= r_thr),
        .o_pick   (w_pick)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        w_ram_raddr  = '0;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_count[IDX_BITS-1:0];
        w_ram_wdata  = w_new_entry;
        w_pick_start = 1'b0;
        w_pick_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((r_mode == MODE_DEQUEUE) && (r_count != '0)) begin
                    w_pick_start = 1'b1;
                    n_idx        = '0;
                    n_state      = S_SCAN;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: begin
                w_pick_valid = 1'b1;
                w_ram_raddr  = IDX_BITS'(r_idx + 1'b1);
                if (CNT_BITS'(r_idx) == w_last) begin
                    n_state = S_SEL;
                end else begin
                    n_idx = IDX_BITS'(r_idx + 1'b1);
                end
            end
            S_SEL: begin
                w_ram_raddr = IDX_BITS'(w_pick.idx + 1'b1);
                n_idx       = IDX_BITS'(w_pick.idx + 1'b1);
                if (CNT_BITS'(w_pick.idx) == w_last) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = IDX_BITS'(r_idx - 1'b1);
                w_ram_wdata = w_ram_rdata;
                w_ram_raddr = IDX_BITS'(r_idx + 1'b1);
                if (CNT_BITS'(r_idx) == w_last) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = IDX_BITS'(r_idx + 1'b1);
                end
            end
            S_RESP: begin
                if (w_resp_fire) begin
                    n_state = S_IDLE;
                    if ((r_mode == MODE_INSERT) && !w_full) begin
                        w_ram_we = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result and state update
    always_comb begin
        n_count  = r_count;
        n_since  = r_since;
        n_fin    = r_fin;
        n_status = ST_ACK;
        n_otag   = '0;
        n_oprio  = '0;
        n_aged   = 1'b0;
        unique case (r_mode)
            MODE_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = CNT_BITS'(r_count + 1'b1);
                end
            end
            MODE_DEQUEUE: begin
                if (r_count == '0) begin
                    n_status = r_fin ? ST_EMPTY_DONE : ST_EMPTY_WAIT;
                end else begin
                    n_status = ST_DISPATCH;
                    n_otag   = r_sel.entry.tag;
                    n_oprio  = r_sel.entry.prio;
                    n_aged   = r_sel.aged;
                    n_count  = w_last;
                    if (r_sel.entry.prio == FREE_PRIORITY) begin
                        n_since = '0;
                    end
                end
            end
            MODE_TICK: begin
                if (r_since != MS_MAX) begin
                    n_since = MS_BITS'(r_since + 1'b1);
                end
            end
            MODE_FINISH: begin
                n_fin = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_since     <= '0;
            r_fin       <= 1'b0;
            r_thr       <= THRESHOLD_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_resp_fire) begin
                r_count     <= n_count;
                r_since     <= n_since;
                r_fin       <= n_fin;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (w_accept) begin
            r_mode <= i_mode;
            r_tag  <= i_job_tag;
            r_prio <= i_job_priority;
        end
        if (r_state == S_SEL) begin
            r_sel <= w_pick;
        end
        if (w_resp_fire) begin
            r_status <= n_status;
            r_otag   <= n_otag;
            r_oprio  <= n_oprio;
            r_aged   <= n_aged;
            r_closed <= n_fin;
            r_occ    <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_job_tag  = r_otag;
    assign o_out_priority = r_oprio;
    assign o_by_aging     = r_aged;
    assign o_closed       = r_closed;
    assign o_occupancy    = r_occ;

    `PQA_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_BITS'(QUEUE_DEPTH), "count over depth")
    `PQA_ASSERT_IMP(a_aged_free, o_out_valid && o_by_aging,
        (o_status == ST_DISPATCH) && (o_out_priority == FREE_PRIORITY),
        "aged dispatch not free class")
    `PQA_ASSERT_IMP(a_dispatch_room, o_out_valid && (o_status == ST_DISPATCH),
        o_occupancy < CNT_BITS'(QUEUE_DEPTH), "dispatch left store full")
    `PQA_ASSERT_NXT(a_accept_exec, w_accept, (r_state == S_EXEC) && !o_in_ready,
        "request not taken into exec")

endmodule
